@@ design/gbp_pkg.sv @@
// Shared types, codes and helper functions of the gradient bevel pixel generator.
package gbp_pkg;

	localparam int PosW  = 10;
	localparam int SizeW = 11;
	localparam int ColW  = 24;
	localparam int RemW  = 20;

	localparam logic [2:0] REG_COLOR_FROM   = 3'd0;
	localparam logic [2:0] REG_COLOR_TO     = 3'd1;
	localparam logic [2:0] REG_WIDTH        = 3'd2;
	localparam logic [2:0] REG_HEIGHT       = 3'd3;
	localparam logic [2:0] REG_GRAD_MODE    = 3'd4;
	localparam logic [2:0] REG_BEVEL_MODE   = 3'd5;
	localparam logic [2:0] REG_BORDER_EN    = 3'd6;
	localparam logic [2:0] REG_BORDER_COLOR = 3'd7;

	localparam logic [1:0] GRAD_SOLID = 2'd0;
	localparam logic [1:0] GRAD_HORIZ = 2'd1;
	localparam logic [1:0] GRAD_VERT  = 2'd2;
	localparam logic [1:0] GRAD_DIAG  = 2'd3;

	localparam logic [1:0] BEVEL_FLAT   = 2'd0;
	localparam logic [1:0] BEVEL_RAISED = 2'd1;
	localparam logic [1:0] BEVEL_SUNKEN = 2'd2;
	localparam logic [1:0] BEVEL_BOTH   = 2'd3;

	localparam logic [1:0] KIND_ZERO = 2'd0;
	localparam logic [1:0] KIND_FLAT = 2'd1;
	localparam logic [1:0] KIND_GRAD = 2'd2;

	typedef struct packed {
		logic                      empty;
		logic [1:0]                kind;
		logic [ColW-1:0]           base;
		logic [3:0]                shade;
		logic                      diag;
		logic [SizeW:0]            da;
		logic [SizeW:0]            db;
		logic [PosW-1:0]           m;
		logic [PosW-1:0]           y;
		logic [2:0][7:0]           c0;
		logic [2:0][8:0]           d;
		logic [2:0][RemW-1:0]      pm;
		logic [2:0][RemW-1:0]      ra;
		logic [2:0][RemW-1:0]      rb;
		logic [2:0][7:0]           qa;
		logic [2:0][7:0]           qb;
		logic [2:0]                neg;
	} pix_t;

	function automatic logic [7:0] brighten(input logic [7:0] v);
		logic [8:0] r;
		r = {1'b0, v} + {2'b0, v[7:1]};
		return r[8] ? 8'd255 : r[7:0];
	endfunction

	function automatic logic [7:0] darken(input logic [7:0] v);
		return {2'b0, v[7:2]} + {1'b0, v[7:1]};
	endfunction

	// two quotient bits per call, starting at bit hi
	function automatic pix_t div_step(input pix_t p, input int hi);
		pix_t r;
		logic [RemW-1:0] sa;
		logic [RemW-1:0] sb;
		r = p;
		for (int ch = 0; ch < 3; ch++) begin
			for (int k = hi; k > hi - 2; k--) begin
				sa = RemW'({{(RemW-SizeW-1){1'b0}}, r.da} << k);
				sb = RemW'({{(RemW-SizeW-1){1'b0}}, r.db} << k);
				if (r.ra[ch] >= sa) begin
					r.ra[ch] = r.ra[ch] - sa;
					r.qa[ch][k] = 1'b1;
				end
				if (r.rb[ch] >= sb) begin
					r.rb[ch] = r.rb[ch] - sb;
					r.qb[ch][k] = 1'b1;
				end
			end
		end
		return r;
	endfunction

endpackage

@@ design/gradient_bevel_pixel_generator.sv @@
// Top level of the gradient bevel pixel generator: config registers and pixel pipeline.
// One pixel request is taken per clock while the output is not stalled, and its color
// leaves through an eight-stage pipeline (setup, multiply, sum, four restoring divider
// stages of two quotient bits each, then bevel shading). A stall at the output holds the
// whole pipeline; nothing is dropped. Write configuration only while the pipeline is empty.
module gradient_bevel_pixel_generator #(
	parameter int MAX_SIZE = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [23:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [9:0]  pos_x,
	input  logic [9:0]  pos_y,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  red,
	output logic [7:0]  green,
	output logic [7:0]  blue,
	output logic        empty_res
);

	logic [23:0] color_from_q, color_to_q, border_color_q;
	logic [10:0] width_q, height_q;
	logic [1:0]  grad_mode_q, bevel_mode_q;
	logic        border_en_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_from_q   <= '0;
			color_to_q     <= '0;
			width_q        <= 11'd1;
			height_q       <= 11'd1;
			grad_mode_q    <= gbp_pkg::GRAD_SOLID;
			bevel_mode_q   <= gbp_pkg::BEVEL_FLAT;
			border_en_q    <= 1'b0;
			border_color_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				gbp_pkg::REG_COLOR_FROM:   color_from_q   <= cfg_data;
				gbp_pkg::REG_COLOR_TO:     color_to_q     <= cfg_data;
				gbp_pkg::REG_WIDTH:        width_q        <= cfg_data[10:0];
				gbp_pkg::REG_HEIGHT:       height_q       <= cfg_data[10:0];
				gbp_pkg::REG_GRAD_MODE:    grad_mode_q    <= cfg_data[1:0];
				gbp_pkg::REG_BEVEL_MODE:   bevel_mode_q   <= cfg_data[1:0];
				gbp_pkg::REG_BORDER_EN:    border_en_q    <= cfg_data[0];
				gbp_pkg::REG_BORDER_COLOR: border_color_q <= cfg_data;
				default: ;
			endcase
		end
	end

	logic en;
	logic [7:0] vld_q;
	gbp_pkg::pix_t pix_s1, pix_s2, pix_s3, pix_s4, pix_s5, pix_s6, pix_s7;
	gbp_pkg::pix_t in_c, mul_c, sum_c;
	logic [7:0] red_s8, green_s8, blue_s8;
	logic       empty_s8;
	logic [2:0][7:0] chan_c;

	assign en       = !vld_q[7] || out_ready;
	assign in_ready = en;
	assign out_valid = vld_q[7];
	assign red       = red_s8;
	assign green     = green_s8;
	assign blue      = blue_s8;
	assign empty_res = empty_s8;

	// setup
	always_comb begin
		logic [11:0] ow, oh;
		logic signed [12:0] ws, hs;
		logic [10:0] w, h;
		logic [9:0] x, y;
		logic [23:0] a, b;
		logic in_rect, border;
		ow = (int'(width_q) > MAX_SIZE) ? 12'(MAX_SIZE) : {1'b0, width_q};
		oh = (int'(height_q) > MAX_SIZE) ? 12'(MAX_SIZE) : {1'b0, height_q};
		ws = $signed({1'b0, ow}) - $signed({11'd0, border_en_q, 1'b0});
		hs = $signed({1'b0, oh}) - $signed({11'd0, border_en_q, 1'b0});
		w = ws[10:0];
		h = hs[10:0];
		x = pos_x - {9'd0, border_en_q};
		y = pos_y - {9'd0, border_en_q};
		a = bevel_mode_q[1] ? color_to_q : color_from_q;
		b = bevel_mode_q[1] ? color_from_q : color_to_q;
		in_rect = ({2'b0, pos_x} < ow) && ({2'b0, pos_y} < oh);
		border = border_en_q && (pos_x == '0 || pos_y == '0 ||
			{2'b0, pos_x} == ow - 12'd1 || {2'b0, pos_y} == oh - 12'd1);
		in_c = '0;
		in_c.empty = (ws <= 0) || (hs <= 0);
		if (in_c.empty || !in_rect) begin
			in_c.kind = gbp_pkg::KIND_ZERO;
		end else if (border) begin
			in_c.kind = gbp_pkg::KIND_FLAT;
			in_c.base = border_color_q;
		end else if (grad_mode_q == gbp_pkg::GRAD_SOLID) begin
			in_c.kind = gbp_pkg::KIND_FLAT;
			in_c.base = a;
		end else begin
			in_c.kind = gbp_pkg::KIND_GRAD;
		end
		if (bevel_mode_q != gbp_pkg::BEVEL_FLAT) begin
			in_c.shade[0] = (y == '0);
			in_c.shade[1] = ({1'b0, y} == h - 11'd1);
			in_c.shade[2] = (h >= 11'd2) && (y != '0) && (x == '0);
			in_c.shade[3] = (h >= 11'd2) && (y != '0) && ({1'b0, x} == w - 11'd1);
		end
		in_c.diag = (grad_mode_q == gbp_pkg::GRAD_DIAG);
		case (grad_mode_q)
			gbp_pkg::GRAD_VERT: in_c.da = {1'b0, h};
			gbp_pkg::GRAD_DIAG: in_c.da = {w, 1'b0};
			default:            in_c.da = {1'b0, w};
		endcase
		in_c.db = {h, 1'b0};
		in_c.m  = (grad_mode_q == gbp_pkg::GRAD_VERT) ? y : x;
		in_c.y  = y;
		for (int ch = 0; ch < 3; ch++) begin
			in_c.c0[ch] = a[8*ch +: 8];
			in_c.d[ch]  = {1'b0, b[8*ch +: 8]} - {1'b0, a[8*ch +: 8]};
		end
	end

	// multiply
	always_comb begin
		mul_c = pix_s1;
		for (int ch = 0; ch < 3; ch++) begin
			mul_c.ra[ch] = 20'(pix_s1.c0[ch] * pix_s1.da);
			mul_c.pm[ch] = 20'($signed({1'b0, pix_s1.m}) * $signed(pix_s1.d[ch]));
			mul_c.rb[ch] = 20'($signed({1'b0, pix_s1.y}) * $signed(pix_s1.d[ch]));
		end
	end

	// sum and magnitude
	always_comb begin
		sum_c = pix_s2;
		for (int ch = 0; ch < 3; ch++) begin
			sum_c.ra[ch]  = pix_s2.ra[ch] + pix_s2.pm[ch];
			sum_c.neg[ch] = pix_s2.rb[ch][19];
			sum_c.rb[ch]  = pix_s2.rb[ch][19] ? 20'(-pix_s2.rb[ch]) : pix_s2.rb[ch];
			sum_c.qa[ch]  = '0;
			sum_c.qb[ch]  = '0;
		end
	end

	// combine and shade
	always_comb begin
		logic [7:0] v, yt;
		for (int ch = 0; ch < 3; ch++) begin
			yt = pix_s7.neg[ch] ? 8'(-pix_s7.qb[ch]) : pix_s7.qb[ch];
			v  = pix_s7.diag ? pix_s7.qa[ch] + yt : pix_s7.qa[ch];
			if (pix_s7.shade[0]) v = gbp_pkg::brighten(v);
			if (pix_s7.shade[1]) v = gbp_pkg::darken(v);
			if (pix_s7.shade[2]) v = gbp_pkg::brighten(v);
			if (pix_s7.shade[3]) v = gbp_pkg::darken(v);
			case (pix_s7.kind)
				gbp_pkg::KIND_FLAT: chan_c[ch] = pix_s7.base[8*ch +: 8];
				gbp_pkg::KIND_GRAD: chan_c[ch] = v;
				default:            chan_c[ch] = 8'd0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[6:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pix_s1   <= in_c;
			pix_s2   <= mul_c;
			pix_s3   <= sum_c;
			pix_s4   <= gbp_pkg::div_step(pix_s3, 7);
			pix_s5   <= gbp_pkg::div_step(pix_s4, 5);
			pix_s6   <= gbp_pkg::div_step(pix_s5, 3);
			pix_s7   <= gbp_pkg::div_step(pix_s6, 1);
			red_s8   <= chan_c[2];
			green_s8 <= chan_c[1];
			blue_s8  <= chan_c[0];
			empty_s8 <= pix_s7.empty;
		end
	end

endmodule

@@ verif/tb_gradient_bevel_pixel_generator.sv @@
// Testbench for the gradient bevel pixel generator: predicts every pixel and checks it.
`timescale 1ns / 1ps
module tb_gradient_bevel_pixel_generator;

	localparam int LIMIT = 400000;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [23:0] cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic [9:0]  pos_x;
	logic [9:0]  pos_y;
	logic        out_valid;
	logic        out_ready;
	logic [7:0]  red;
	logic [7:0]  green;
	logic [7:0]  blue;
	logic        empty_res;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		logic       e;
	} pixel_t;

	pixel_t pixel_q[$];
	logic [23:0] m_from, m_to, m_bcol;
	int          m_width, m_hgt;
	logic [1:0]  m_grad, m_bevel;
	logic        m_bden;
	int          errors = 0;
	int          cycles = 0;
	bit          gaps_on;

	gradient_bevel_pixel_generator u_top (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	function automatic int lighten(int v);
		int r;
		r = v + (v >> 1);
		return r > 255 ? 255 : r;
	endfunction

	function automatic int dim(int v);
		return (v >> 2) + (v >> 1);
	endfunction

	function automatic int channel_value(int a, int b, int x, int y, int w, int h);
		int d, xt, t, yt, v;
		d = b - a;
		if (m_grad == gbp_pkg::GRAD_HORIZ) v = (a * w + x * d) / w;
		else if (m_grad == gbp_pkg::GRAD_VERT) v = (a * h + y * d) / h;
		else begin
			xt = (a * 2 * w + x * d) / (2 * w);
			t = y * d;
			yt = t >= 0 ? t / (2 * h) : -((-t) / (2 * h));
			v = (xt + yt) & 255;
		end
		if (m_bevel != gbp_pkg::BEVEL_FLAT) begin
			if (y == 0) v = lighten(v);
			if (y == h - 1) v = dim(v);
			if (h >= 2 && y >= 1) begin
				if (x == 0) v = lighten(v);
				if (x == w - 1) v = dim(v);
			end
		end
		return v & 255;
	endfunction

	function automatic pixel_t pixel_color(int px, int py);
		pixel_t p;
		int ow, oh, bd, w, h, x, y;
		logic [23:0] a, b, col;
		ow = m_width > 1024 ? 1024 : m_width;
		oh = m_hgt > 1024 ? 1024 : m_hgt;
		bd = int'(m_bden);
		w = ow - 2 * bd;
		h = oh - 2 * bd;
		col = '0;
		p.e = 1'b0;
		if (w <= 0 || h <= 0) p.e = 1'b1;
		else if (px < ow && py < oh) begin
			if (bd != 0 && (px == 0 || py == 0 || px == ow - 1 || py == oh - 1)) col = m_bcol;
			else begin
				a = m_bevel[1] ? m_to : m_from;
				b = m_bevel[1] ? m_from : m_to;
				x = px - bd;
				y = py - bd;
				if (m_grad == gbp_pkg::GRAD_SOLID) col = a;
				else for (int s = 0; s <= 16; s += 8)
					col[s +: 8] = 8'(channel_value((a >> s) & 255, (b >> s) & 255,
						x, y, w, h));
			end
		end
		p.r = col[23:16];
		p.g = col[15:8];
		p.b = col[7:0];
		return p;
	endfunction

	always @(posedge clk) begin
		pixel_t exp_p;
		if (arst_n && out_valid && out_ready) begin
			if (pixel_q.size() == 0) begin
				$error("pixel with no request pending");
				errors++;
			end else begin
				exp_p = pixel_q.pop_front();
				if (red !== exp_p.r) begin
					$error("red exp %0d got %0d", exp_p.r, red); errors++;
				end
				if (green !== exp_p.g) begin
					$error("green exp %0d got %0d", exp_p.g, green); errors++;
				end
				if (blue !== exp_p.b) begin
					$error("blue exp %0d got %0d", exp_p.b, blue); errors++;
				end
				if (empty_res !== exp_p.e) begin
					$error("empty_res exp %0d got %0d", exp_p.e, empty_res); errors++;
				end
			end
		end
	end

	always @(negedge clk) begin
		if (!gaps_on) out_ready <= 1'b1;
		else if ($urandom_range(0, 19) == 0) out_ready <= 1'b0;
		else if ($urandom_range(0, 9) == 0) out_ready <= ($urandom_range(0, 3) == 0);
		else out_ready <= 1'b1;
	end

	function automatic int gap_len();
		return $urandom_range(0, 9) == 0 ? $urandom_range(5, 30) : $urandom_range(0, 2);
	endfunction

	task automatic send_pixel(input logic [9:0] x, input logic [9:0] y);
		int g;
		g = gaps_on ? gap_len() : 0;
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(negedge clk);
		end
		in_valid <= 1'b1;
		pos_x <= x;
		pos_y <= y;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		pixel_q.push_back(pixel_color(int'(x), int'(y)));
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [23:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		case (idx)
			gbp_pkg::REG_COLOR_FROM:   m_from = val;
			gbp_pkg::REG_COLOR_TO:     m_to = val;
			gbp_pkg::REG_WIDTH:        m_width = int'(val[10:0]);
			gbp_pkg::REG_HEIGHT:       m_hgt = int'(val[10:0]);
			gbp_pkg::REG_GRAD_MODE:    m_grad = val[1:0];
			gbp_pkg::REG_BEVEL_MODE:   m_bevel = val[1:0];
			gbp_pkg::REG_BORDER_EN:    m_bden = val[0];
			gbp_pkg::REG_BORDER_COLOR: m_bcol = val;
			default: ;
		endcase
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pixel_q.size() != 0) @(negedge clk);
		repeat (12) @(negedge clk);
	endtask

	task automatic setup(input logic [23:0] f, input logic [23:0] t, input int w,
			input int h, input logic [1:0] gm, input logic [1:0] bm, input logic be,
			input logic [23:0] bc);
		drain();
		write_reg(gbp_pkg::REG_COLOR_FROM, f);
		write_reg(gbp_pkg::REG_COLOR_TO, t);
		write_reg(gbp_pkg::REG_WIDTH, 24'(w));
		write_reg(gbp_pkg::REG_HEIGHT, 24'(h));
		write_reg(gbp_pkg::REG_GRAD_MODE, {22'd0, gm});
		write_reg(gbp_pkg::REG_BEVEL_MODE, {22'd0, bm});
		write_reg(gbp_pkg::REG_BORDER_EN, {23'd0, be});
		write_reg(gbp_pkg::REG_BORDER_COLOR, bc);
		cfg_we <= 1'b0;
	endtask

	task automatic test_corners();
		setup(24'h000000, 24'hFFFFFF, 1024, 1024, gbp_pkg::GRAD_DIAG, gbp_pkg::BEVEL_RAISED,
			1'b1, 24'hA5A5A5);
		send_pixel(0, 0);
		send_pixel(1023, 1023);
		send_pixel(1, 1);
		send_pixel(1022, 1022);
		send_pixel(1, 1022);
		send_pixel(1022, 1);
		send_pixel(512, 300);
		setup(24'hFFFFFF, 24'h000000, 2047, 5, gbp_pkg::GRAD_HORIZ, gbp_pkg::BEVEL_BOTH,
			1'b0, 24'h5A5A5A);
		send_pixel(0, 0);
		send_pixel(1023, 4);
		send_pixel(0, 4);
		send_pixel(5, 7);
	endtask

	task automatic test_degenerate();
		setup(24'h123456, 24'hFEDCBA, 2, 7, gbp_pkg::GRAD_VERT, gbp_pkg::BEVEL_RAISED,
			1'b1, 24'h0);
		send_pixel(0, 3);
		send_pixel(1, 1);
		setup(24'h80FF01, 24'h01FF80, 7, 3, gbp_pkg::GRAD_VERT, gbp_pkg::BEVEL_SUNKEN,
			1'b1, 24'hFFFFFF);
		send_pixel(3, 1);
		send_pixel(0, 1);
		send_pixel(9, 1);
		setup(24'h80FF01, 24'h01FF80, 3, 9, gbp_pkg::GRAD_HORIZ, gbp_pkg::BEVEL_RAISED,
			1'b1, 24'hFFFFFF);
		send_pixel(1, 0);
		send_pixel(1, 4);
		send_pixel(1, 7);
		setup(24'hC0C0C0, 24'h101010, 9, 9, gbp_pkg::GRAD_SOLID, gbp_pkg::BEVEL_RAISED,
			1'b0, 24'h0);
		send_pixel(0, 0);
		send_pixel(8, 8);
		send_pixel(1, 1);
	endtask

	task automatic test_random();
		int w, h;
		gaps_on = 1;
		for (int ph = 0; ph < 39; ph++) begin
			w = $urandom_range(0, 9) == 0 ? $urandom_range(0, 2047) : $urandom_range(0, 40);
			h = $urandom_range(0, 9) == 0 ? $urandom_range(0, 2047) : $urandom_range(0, 40);
			setup(24'($urandom), 24'($urandom), w, h, 2'($urandom_range(0, 3)),
				2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), 24'($urandom));
			for (int i = 0; i < 50; i++) begin
				if ($urandom_range(0, 7) == 0) send_pixel(10'($urandom), 10'($urandom));
				else send_pixel(10'($urandom_range(0, w + 1)), 10'($urandom_range(0, h + 1)));
			end
		end
	endtask

	initial begin
		arst_n = 0;
		cfg_we = 0;
		cfg_index = gbp_pkg::REG_COLOR_FROM;
		cfg_data = 0;
		in_valid = 0;
		pos_x = 0;
		pos_y = 0;
		gaps_on = 0;
		m_from = 0; m_to = 0; m_width = 1; m_hgt = 1;
		m_grad = gbp_pkg::GRAD_SOLID; m_bevel = gbp_pkg::BEVEL_FLAT; m_bden = 0; m_bcol = 0;
		repeat (9) @(negedge clk);
		arst_n = 1;
		@(negedge clk);
		send_pixel(0, 0);
		test_corners();
		test_degenerate();
		test_random();
		drain();
		if (errors == 0) $display("Verification passed");
		else $display("Verification failed");
		$finish;
	end

endmodule
